### rtl/sacl_pkg.sv
// types, constants and state codes shared by the set-associative lfu cache
package sacl_pkg;

  localparam int TAG_W       = 31;
  localparam int CNT_W       = 32;
  localparam int NUM_SETS_W  = 7;
  localparam int NUM_WAYS_W  = 4;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int WAY_OUT_W   = 3;
  localparam int SET_OUT_W   = 6;

  localparam int DEF_MAX_SETS = 64;
  localparam int DEF_MAX_WAYS = 8;

  localparam logic [NUM_SETS_W-1:0] RST_NUM_SETS = 7'd64;
  localparam logic [NUM_WAYS_W-1:0] RST_NUM_WAYS = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_SETS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_WAYS = 1'b1;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // remainder unit: four quotient bits per cycle over a 32 bit dividend
  localparam int MOD_DVD_W = 32;
  localparam int MOD_STEPS = 4;
  localparam int MOD_ITERS = MOD_DVD_W / MOD_STEPS;
  localparam int MOD_CNT_W = $clog2(MOD_ITERS);

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] cnt;
  } sacl_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOOK,
    ST_SCAN,
    ST_WRITE
  } sacl_state_e;

endpackage

### rtl/set_assoc_cache_lfu_unit.sv
// top level of the set-associative cache with lfu replacement
// flow: set index from an 8-step remainder unit, then read, lookup and write of one set row;
//   on a miss with no empty way and more than one way in use the lfu victim scan runs (one way per cycle)
// input is stalled from an accepted reference until its result is loaded, so one
//   transaction is in flight at a time; the write waits while the output is stalled
// reset: config back to 64 sets and 8 ways, miss total zero, then a clearing pass
//   writes every set row empty while input is stalled
module set_assoc_cache_lfu_unit import sacl_pkg::*; #(
  parameter int MAX_SETS = DEF_MAX_SETS,
  parameter int MAX_WAYS = DEF_MAX_WAYS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [TAG_W-1:0]      reference_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output logic [WAY_OUT_W-1:0]  way_used_o,
  output logic [SET_OUT_W-1:0]  set_used_o,
  output logic [CNT_W-1:0]      miss_total_o
);

  localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAYC_W   = $clog2(MAX_WAYS + 1);
  localparam int SETS_CAP = (MAX_SETS < 127) ? MAX_SETS : 127;
  localparam int ROW_W    = MAX_WAYS * $bits(sacl_entry_t);

  sacl_state_e state_q, state_d;

  logic [NUM_SETS_W-1:0] num_sets_q;
  logic [NUM_WAYS_W-1:0] num_ways_q;
  logic [NUM_SETS_W-1:0] sets_eff;
  logic [WAYC_W-1:0]     ways_eff;

  logic [SET_W-1:0] clr_q, clr_d;
  logic [CNT_W-1:0] miss_q, miss_d;
  logic             out_valid_q, out_valid_d;

  logic [TAG_W-1:0] ref_q;
  logic [SET_W-1:0] set_q;
  logic             hit_q;
  logic [WAY_W-1:0] chosen_q, chosen_d;
  logic [WAY_W-1:0] scan_q, scan_d;
  logic [CNT_W-1:0] min_q, min_d;
  sacl_entry_t [MAX_WAYS-1:0] row_q;
  sacl_entry_t [MAX_WAYS-1:0] row_rd;
  sacl_entry_t [MAX_WAYS-1:0] row_wr;

  logic                 out_hit_q;
  logic [WAY_OUT_W-1:0] out_way_q;
  logic [SET_OUT_W-1:0] out_set_q;

  logic             mod_start;
  logic             mod_done;
  logic [NUM_SETS_W-1:0] mod_rem;

  logic             ram_we;
  logic [SET_W-1:0] ram_addr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;

  logic [MAX_WAYS-1:0] hitv;
  logic [MAX_WAYS-1:0] emptyv;
  logic [WAY_W-1:0]    hit_idx;
  logic [WAY_W-1:0]    empty_idx;
  logic                hit_any;
  logic                empty_any;
  logic                out_free;
  logic                out_load;
  logic                in_fire;
  logic                scan_less;
  logic                scan_last;

  // clamp configured counts into the usable range
  always_comb begin
    if (num_sets_q == '0) begin
      sets_eff = NUM_SETS_W'(1);
    end else if (int'(num_sets_q) > SETS_CAP) begin
      sets_eff = NUM_SETS_W'(SETS_CAP);
    end else begin
      sets_eff = num_sets_q;
    end
    if (num_ways_q == '0) begin
      ways_eff = WAYC_W'(1);
    end else if (int'(num_ways_q) > MAX_WAYS) begin
      ways_eff = WAYC_W'(MAX_WAYS);
    end else begin
      ways_eff = WAYC_W'(num_ways_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_sets_q <= RST_NUM_SETS;
      num_ways_q <= RST_NUM_WAYS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUM_SETS: num_sets_q <= cfg_wdata_i[NUM_SETS_W-1:0];
        REG_NUM_WAYS: num_ways_q <= cfg_wdata_i[NUM_WAYS_W-1:0];
      endcase
    end
  end

  sacl_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (reference_i),
    .divisor_i  (sets_eff),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign row_rd   = ram_rdata;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_fire  = in_valid_i && !in_stall_o;

  // tag match and empty way search over the ways in use
  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      hitv[w]   = (w < int'(ways_eff)) && row_rd[w].valid && (row_rd[w].tag == ref_q);
      emptyv[w] = (w < int'(ways_eff)) && !row_rd[w].valid;
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hitv[w]) begin
        hit_idx = WAY_W'(w);
      end
      if (emptyv[w]) begin
        empty_idx = WAY_W'(w);
      end
    end
    hit_any   = |hitv;
    empty_any = |emptyv;
  end

  assign scan_less = row_q[scan_q].cnt < min_q;
  assign scan_last = scan_q == WAY_W'(ways_eff - 1'b1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == SET_W'(MAX_SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (hit_any || empty_any || ways_eff == WAYC_W'(1)) begin
          state_d = ST_WRITE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs of the control
  always_comb begin
    in_stall_o = 1'b1;
    mod_start  = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = set_q;
    ram_wdata  = row_wr;
    out_load   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        mod_start  = in_valid_i;
      end
      ST_WRITE: begin
        ram_we   = out_free;
        out_load = out_free;
      end
      ST_DIV, ST_READ, ST_LOOK, ST_SCAN: begin
      end
      default: begin
      end
    endcase
  end

  // modified row and victim choice
  always_comb begin
    row_wr = row_q;
    if (hit_q) begin
      if (row_q[chosen_q].cnt != COUNT_MAX) begin
        row_wr[chosen_q].cnt = row_q[chosen_q].cnt + 1'b1;
      end
    end else begin
      row_wr[chosen_q].valid = 1'b1;
      row_wr[chosen_q].tag   = ref_q;
      row_wr[chosen_q].cnt   = CNT_W'(1);
    end

    chosen_d = chosen_q;
    scan_d   = scan_q;
    min_d    = min_q;
    if (state_q == ST_LOOK) begin
      min_d  = row_rd[0].cnt;
      scan_d = WAY_W'(1);
      if (hit_any) begin
        chosen_d = hit_idx;
      end else if (empty_any) begin
        chosen_d = empty_idx;
      end else begin
        chosen_d = '0;
      end
    end else if (state_q == ST_SCAN) begin
      scan_d = scan_q + 1'b1;
      if (scan_less) begin
        min_d    = row_q[scan_q].cnt;
        chosen_d = scan_q;
      end
    end

    miss_d = miss_q;
    if (out_load && !hit_q && miss_q != COUNT_MAX) begin
      miss_d = miss_q + 1'b1;
    end

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    clr_d = clr_q;
    if (state_q == ST_CLEAR) begin
      clr_d = clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      miss_q      <= miss_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ref_q <= reference_i;
    end
    if (state_q == ST_DIV && mod_done) begin
      set_q <= SET_W'(mod_rem);
    end
    if (state_q == ST_LOOK) begin
      row_q <= row_rd;
      hit_q <= hit_any;
    end
    chosen_q <= chosen_d;
    scan_q   <= scan_d;
    min_q    <= min_d;
    if (out_load) begin
      out_hit_q <= hit_q;
      out_way_q <= WAY_OUT_W'(chosen_q);
      out_set_q <= SET_OUT_W'(set_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign way_used_o   = out_way_q;
  assign set_used_o   = out_set_q;
  assign miss_total_o = miss_q;

`ifndef SYNTHESIS
  a_miss_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> miss_q >= $past(miss_q))
    else $error("miss total decreased");

  a_way_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> int'(chosen_q) < int'(ways_eff))
    else $error("chosen way outside the ways in use");

  a_mod_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> state_q == ST_DIV)
    else $error("remainder finished outside the divide state");
`endif

endmodule

### rtl/sacl_ram.sv
// generic single-port ram with registered read
module sacl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sacl_mod.sv
// iterative remainder unit, reference modulo set count
module sacl_mod import sacl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [TAG_W-1:0]      dividend_i,
  input  logic [NUM_SETS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [NUM_SETS_W-1:0] rem_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [MOD_CNT_W-1:0]  cnt_q, cnt_d;
  logic [NUM_SETS_W-1:0] rem_q, rem_d;
  logic [MOD_DVD_W-1:0]  dvd_q, dvd_d;
  logic [NUM_SETS_W-1:0] div_q, div_d;
  logic [NUM_SETS_W-1:0] rem_nx;
  logic [MOD_DVD_W-1:0]  dvd_nx;

  // restoring steps on the partial remainder
  always_comb begin
    logic [NUM_SETS_W:0]   t;
    logic [NUM_SETS_W-1:0] r;
    logic [MOD_DVD_W-1:0]  d;
    r = rem_q;
    d = dvd_q;
    for (int k = 0; k < MOD_STEPS; k++) begin
      t = {r, d[MOD_DVD_W-1]};
      d = d << 1;
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      r = t[NUM_SETS_W-1:0];
    end
    rem_nx = r;
    dvd_nx = d;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = MOD_DVD_W'(dividend_i);
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = rem_nx;
      dvd_d = dvd_nx;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MOD_CNT_W'(MOD_ITERS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### dv/set_assoc_cache_lfu_unit_tb.sv
// testbench for the set-associative cache with lfu replacement: directed and random lookups
module set_assoc_cache_lfu_unit_tb import sacl_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SETS = DEF_MAX_SETS;
  localparam int MAX_WAYS = DEF_MAX_WAYS;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD_CYCLES = 240;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [SET_OUT_W-1:0] set_idx;
    logic [CNT_W-1:0]     misses;
  } lookup_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_NUM_SETS;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [TAG_W-1:0]     reference_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 hit_o;
  logic [WAY_OUT_W-1:0] way_used_o;
  logic [SET_OUT_W-1:0] set_used_o;
  logic [CNT_W-1:0]     miss_total_o;

  set_assoc_cache_lfu_unit #(
    .MAX_SETS(MAX_SETS),
    .MAX_WAYS(MAX_WAYS)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .reference_i(reference_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .hit_o(hit_o),
    .way_used_o(way_used_o),
    .set_used_o(set_used_o),
    .miss_total_o(miss_total_o)
  );

  always #1 clk_i = ~clk_i;

  // cache mirror
  logic [TAG_W-1:0]      mir_tag [MAX_SETS*MAX_WAYS];
  bit                    mir_valid [MAX_SETS*MAX_WAYS];
  logic [CNT_W-1:0]      mir_cnt [MAX_SETS*MAX_WAYS];
  logic [CNT_W-1:0]      mir_misses = '0;
  logic [NUM_SETS_W-1:0] sets_reg = RST_NUM_SETS;
  logic [NUM_WAYS_W-1:0] ways_reg = RST_NUM_WAYS;

  lookup_t lookups_pending[$];
  int      errors = 0;

  bit rx_stall_en = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int rx_run = 0;
  bit rx_level = 1'b0;

  initial begin
    for (int i = 0; i < MAX_SETS*MAX_WAYS; i++) begin
      mir_tag[i] = '0;
      mir_valid[i] = 1'b0;
      mir_cnt[i] = '0;
    end
  end

  function automatic int unsigned eff_sets();
    if (sets_reg == 0) return 1;
    if (sets_reg > MAX_SETS) return MAX_SETS;
    return sets_reg;
  endfunction

  function automatic int unsigned eff_ways();
    if (ways_reg == 0) return 1;
    if (ways_reg > MAX_WAYS) return MAX_WAYS;
    return ways_reg;
  endfunction

  function automatic lookup_t lookup_lfu(input logic [TAG_W-1:0] r);
    lookup_t     res;
    int unsigned set_idx;
    int unsigned base;
    int unsigned ways;
    int unsigned pick;
    bit          found;
    bit          empty;
    set_idx = r % eff_sets();
    ways = eff_ways();
    base = set_idx * MAX_WAYS;
    pick = 0;
    found = 1'b0;
    empty = 1'b0;
    for (int w = 0; w < ways; w++) begin
      if (!found && mir_valid[base+w] && mir_tag[base+w] == r) begin
        found = 1'b1;
        pick = w;
      end
    end
    if (found) begin
      if (mir_cnt[base+pick] != COUNT_MAX) mir_cnt[base+pick]++;
    end else begin
      for (int w = 0; w < ways; w++) begin
        if (!empty && !mir_valid[base+w]) begin
          empty = 1'b1;
          pick = w;
        end
      end
      if (!empty) begin
        pick = 0;
        for (int w = 1; w < ways; w++)
          if (mir_cnt[base+w] < mir_cnt[base+pick]) pick = w;
      end
      mir_tag[base+pick] = r;
      mir_valid[base+pick] = 1'b1;
      mir_cnt[base+pick] = 1;
      if (mir_misses != COUNT_MAX) mir_misses++;
    end
    res.hit = found;
    res.way = pick[WAY_OUT_W-1:0];
    res.set_idx = set_idx[SET_OUT_W-1:0];
    res.misses = mir_misses;
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    lookup_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lookups_pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0b way=%0d set=%0d misses=%0d", $realtime,
                 hit_o, way_used_o, set_used_o, miss_total_o);
        errors++;
      end else begin
        exp = lookups_pending.pop_front();
        if (hit_o !== exp.hit) begin
          $display("%0t: hit expected %0b actual %0b", $realtime, exp.hit, hit_o);
          errors++;
        end
        if (way_used_o !== exp.way) begin
          $display("%0t: way_used expected %0d actual %0d", $realtime, exp.way, way_used_o);
          errors++;
        end
        if (set_used_o !== exp.set_idx) begin
          $display("%0t: set_used expected %0d actual %0d", $realtime, exp.set_idx,
                   set_used_o);
          errors++;
        end
        if (miss_total_o !== exp.misses) begin
          $display("%0t: miss_total expected %0d actual %0d", $realtime, exp.misses,
                   miss_total_o);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = LONG_HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!rx_stall_en) begin
      out_stall_i <= 1'b0;
    end else begin
      if (rx_run == 0) begin
        rx_level = ~rx_level;
        rx_run = rx_level ? $urandom_range(1, 6) : $urandom_range(1, 10);
      end else begin
        rx_run--;
      end
      out_stall_i <= rx_level;
    end
  end

  task automatic send_ref(input logic [TAG_W-1:0] r);
    in_valid_i <= 1'b1;
    reference_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    lookups_pending.push_back(lookup_lfu(r));
  endtask

  task automatic idle_cycles(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (lookups_pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_config(input int unsigned sets, input int unsigned ways);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_NUM_SETS;
    cfg_wdata_i <= CFG_W'(sets);
    @(posedge clk_i);
    sets_reg = NUM_SETS_W'(sets);
    cfg_idx_i <= REG_NUM_WAYS;
    cfg_wdata_i <= CFG_W'(ways & 4'hF);
    @(posedge clk_i);
    ways_reg = NUM_WAYS_W'(ways);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [TAG_W-1:0] pick_ref(input int unsigned base);
    int unsigned sets;
    int unsigned s;
    int unsigned k;
    sets = eff_sets();
    case ($urandom_range(0, 9))
      0, 1: return TAG_W'($urandom());
      2: return TAG_W'(32'h7FFF_FFFF - $urandom_range(0, 3 * sets));
      default: begin
        s = $urandom_range(0, ($urandom_range(0, 1) || sets < 4) ? sets - 1 : 3);
        k = $urandom_range(0, eff_ways() + 2);
        return TAG_W'(s + sets * (base + k));
      end
    endcase
  endfunction

  task automatic test_field_extremes();
    send_ref('0);
    send_ref('1);
    send_ref('0);
    send_ref(31'h2AAA_AAAA);
    send_ref(31'h5555_5555);
    send_ref('1);
  endtask

  task automatic test_lfu_victim();
    apply_config(4, 2);
    send_ref(1);
    send_ref(5);
    send_ref(1);
    send_ref(9);
    send_ref(9);
    send_ref(13);
    send_ref(17);
  endtask

  task automatic test_count_clamping();
    apply_config(0, 0);
    send_ref(7);
    send_ref(8);
    apply_config(127, 15);
    send_ref(70);
    send_ref(134);
    send_ref(6);
  endtask

  task automatic test_reconfig_keeps_entries();
    apply_config(4, 4);
    send_ref(2);
    send_ref(6);
    send_ref(10);
    send_ref(14);
    apply_config(4, 2);
    send_ref(10);
    apply_config(4, 4);
    send_ref(10);
    send_ref(14);
  endtask

  task automatic run_random_phase(input int unsigned sets, input int unsigned ways,
                                  input int n, input bit gaps_on, input bit stalls_on,
                                  input bit long_hold);
    int unsigned base;
    int          burst;
    apply_config(sets, ways);
    rx_stall_en = stalls_on;
    base = $urandom_range(0, 32'h7FFF_FFFF / eff_sets() - 16);
    burst = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      if (long_hold && i == 3) hold_req = 1'b1;
      if (i == n / 2 && $urandom_range(0, 1)) wait_drained();
      send_ref(pick_ref(base));
      if (gaps_on) begin
        burst--;
        if (burst == 0) begin
          idle_cycles($urandom_range(1, 12));
          burst = $urandom_range(1, 16);
        end
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(64, 8, 45, 1'b1, 1'b1, 1'b0);
    run_random_phase(1, 1, 45, 1'b0, 1'b0, 1'b0);
    run_random_phase(1, 8, 45, $urandom_range(0, 1), 1'b1, 1'b1);
    run_random_phase(64, 1, 45, $urandom_range(0, 1), $urandom_range(0, 1), 1'b0);
    run_random_phase(3, 5, 45, 1'b1, 1'b1, 1'b0);
    run_random_phase(0, 0, 40, $urandom_range(0, 1), 1'b1, 1'b0);
    run_random_phase(100, 12, 45, 1'b1, $urandom_range(0, 1), 1'b0);
    run_random_phase(127, 15, 40, $urandom_range(0, 1), 1'b1, 1'b0);
    wait_drained();
    run_random_phase($urandom_range(1, 8), $urandom_range(1, 8), 50, 1'b1, 1'b1, 1'b0);
    run_random_phase($urandom_range(0, 127), $urandom_range(0, 15), 50, 1'b1, 1'b1, 1'b0);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    test_field_extremes();
    test_lfu_victim();
    test_count_clamping();
    test_reconfig_keeps_entries();
    test_random_traffic();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
